FILE: hdl/vrs_pkg.sv
// Package for the 26-direction route stepper.
// Holds register codes, reset values, controller states and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package vrs_pkg;

    localparam int COORD_BITS_DEFAULT = 6;

    localparam int RATIO_W  = 8;
    localparam int THRESH_W = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_SCALE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_THRESHOLD = 1'b1;

    localparam logic [RATIO_W-1:0]  RATIO_RESET  = 8'd10;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ANALYSE,
        ST_DECIDE
    } vrs_state_t;

    typedef struct packed {
        logic load;     // capture source and destination
        logic init;     // load step count from the Chebyshev distance
        logic analyse;  // register magnitudes, major axis and scaled largest
        logic step;     // emit the cursor and move it one step back
    } vrs_cmd_t;

    typedef struct packed {
        logic dist_zero; // current remaining vector is zero
        logic last_step; // one point still due
        logic out_free;  // output register can take a point
    } vrs_status_t;

endpackage

`default_nettype wire

FILE: hdl/vector_route_stepper_26dir.sv
// Top level of the 26-direction route stepper.
// Joins vrs_ctrl and vrs_datapath; depends on vrs_pkg.
`default_nettype none

// Channel  Direction  Transaction carries
// s_       in         one route request: source and destination point
// m_       out        one route point, m_tlast on the final point
// cfg_     in         one settings write: ratio_scale or cone_threshold
//
// A request of Chebyshev distance D yields D points; each point passes an analyse
// step (register the remaining vector) and a decide step (multiply-compare and
// step), which an output stall holds; a request of distance zero returns to idle
// from the init state. The loop through cursor, magnitude select and the
// scaled-ratio compare is cut by the registered magnitudes and scaled ratio.
// Reset (aresetn low, synchronous) restores the settings to their defaults and
// drops any route in progress. A stalled m_ tready holds the stepper in its
// decide state; the next request is taken as soon as the final point is
// registered, while that point still waits.

module vector_route_stepper_26dir #(
    parameter int COORD_BITS = vrs_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata, lowest bit up: src_x, src_y, src_z, dst_x, dst_y, dst_z
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // m_tdata, lowest bit up: point_x, point_y, point_z; m_tlast: last_point
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [vrs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vrs_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import vrs_pkg::*;

    localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;

    vrs_cmd_t    cmd;
    vrs_status_t status;
    logic [3*COORD_BITS-1:0] point;

    // sequence load, analyse and step
    vrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold cursor, settings and the output register
    vrs_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fields (s_tdata[6*COORD_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_point   (point),
        .m_last    (m_tlast)
    );

    // pad the point fields with zeros up to whole bytes
    assign m_tdata = OUT_W'(point);

endmodule

`default_nettype wire

FILE: hdl/vrs_ctrl.sv
// Controller state machine of the route stepper.
// Depends on vrs_pkg for states and the command/status structs.
`default_nettype none

module vrs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vrs_pkg::vrs_status_t status,
    output vrs_pkg::vrs_cmd_t    cmd
);
    import vrs_pkg::*;

    vrs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_INIT;
            end
            ST_INIT: begin
                state_next = status.dist_zero ? ST_IDLE : ST_DECIDE;
            end
            ST_ANALYSE: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    state_next = status.last_step ? ST_IDLE : ST_ANALYSE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_INIT: begin
                cmd.init    = 1'b1;
                cmd.analyse = 1'b1;
            end
            ST_ANALYSE: begin
                cmd.analyse = 1'b1;
            end
            ST_DECIDE: begin
                cmd.step = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/vrs_datapath.sv
// Datapath of the route stepper: cursor, source, step count, settings,
// direction logic and the output register. Depends on vrs_pkg.
`default_nettype none

module vrs_datapath #(
    parameter int COORD_BITS = vrs_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [6*COORD_BITS-1:0]         in_fields,
    input  logic                            cfg_we,
    input  logic [vrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  vrs_pkg::vrs_cmd_t               cmd,
    output vrs_pkg::vrs_status_t            status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3*COORD_BITS-1:0]         m_point,
    output logic                            m_last
);
    import vrs_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int LR_W  = C + RATIO_W;
    localparam int TM_W  = C + THRESH_W + 1;

    logic [RATIO_W-1:0]  ratio_reg;
    logic [THRESH_W-1:0] thresh_reg;

    logic [C-1:0] src_reg    [3];
    logic [C-1:0] cursor_reg [3];
    logic [C:0]   steps_reg;

    logic [C-1:0] mag_reg   [3];
    logic [2:0]   neg_reg;
    logic [2:0]   major_reg;
    logic [LR_W-1:0] lr_reg;

    logic            out_valid_reg;
    logic [3*C-1:0]  out_point_reg;
    logic            out_last_reg;

    logic signed [C:0] diff   [3];
    logic [C:0]        abs_w  [3];
    logic [C-1:0]      mag_w  [3];
    logic [2:0]        major_w;
    logic [C-1:0]      l_mag;
    logic [LR_W-1:0]   lr_w;
    logic [THRESH_W:0] thresh_p1;
    logic [TM_W-1:0]   tm_w   [3];
    logic [2:0]        step_en;
    logic              out_free;

    // settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg  <= RATIO_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RATIO_SCALE:    ratio_reg  <= cfg_wdata[RATIO_W-1:0];
                CFG_CONE_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // remaining vector and its magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i]  = $signed({cursor_reg[i][C-1], cursor_reg[i]})
                     - $signed({src_reg[i][C-1], src_reg[i]});
            abs_w[i] = diff[i][C] ? (C+1)'(-diff[i]) : diff[i];
            mag_w[i] = abs_w[i][C-1:0];
        end
        // ties go to x, then y
        if (mag_w[0] >= mag_w[1] && mag_w[0] >= mag_w[2]) begin
            major_w = 3'b001;
            l_mag   = mag_w[0];
        end else if (mag_w[1] >= mag_w[2]) begin
            major_w = 3'b010;
            l_mag   = mag_w[1];
        end else begin
            major_w = 3'b100;
            l_mag   = mag_w[2];
        end
        lr_w = LR_W'(l_mag) * LR_W'(ratio_reg);
    end

    // floor(L*r/m) <= T  is  L*r < (T+1)*m for m > 0
    always_comb begin
        thresh_p1 = {1'b0, thresh_reg} + 1'b1;
        for (int i = 0; i < 3; i++) begin
            tm_w[i]    = TM_W'(thresh_p1) * TM_W'(mag_reg[i]);
            step_en[i] = major_reg[i]
                       | ((mag_reg[i] != '0) && (TM_W'(lr_reg) < tm_w[i]));
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                src_reg[i]    <= in_fields[i*C +: C];
                cursor_reg[i] <= in_fields[(i+3)*C +: C];
            end
        end else if (cmd.step) begin
            for (int i = 0; i < 3; i++) begin
                if (step_en[i]) begin
                    cursor_reg[i] <= neg_reg[i] ? cursor_reg[i] + 1'b1
                                                : cursor_reg[i] - 1'b1;
                end
            end
        end
        if (cmd.analyse) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= mag_w[i];
                neg_reg[i] <= diff[i][C];
            end
            major_reg <= major_w;
            lr_reg    <= lr_w;
        end
        if (cmd.step) begin
            out_point_reg <= {cursor_reg[2], cursor_reg[1], cursor_reg[0]};
            out_last_reg  <= (steps_reg == (C+1)'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.init) begin
                steps_reg <= {1'b0, l_mag};
            end else if (cmd.step) begin
                steps_reg <= steps_reg - 1'b1;
            end
            if (cmd.step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.dist_zero = (l_mag == '0);
    assign status.last_step = (steps_reg == (C+1)'(1));
    assign status.out_free  = out_free;

    assign m_valid = out_valid_reg;
    assign m_point = out_point_reg;
    assign m_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: test/tb_vector_route_stepper_26dir.sv
// Testbench for vector_route_stepper_26dir: streams route requests, predicts the
// route points in a scoreboard class and checks every point as it leaves the block.
// Depends on vrs_pkg and the RTL of the block; needs nothing else.
`default_nettype none

module tb_vector_route_stepper_26dir;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = vrs_pkg::COORD_BITS_DEFAULT;
    localparam int REQ_W      = ((6*COORD_BITS+7)/8)*8;
    localparam int PNT_W      = ((3*COORD_BITS+7)/8)*8;
    localparam int MAX_REPORTS   = 10;
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction on either side
    localparam int HOLD_OFF      = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 16;    // covers a zero-distance request still in flight
    localparam int NUM_PHASES    = 8;
    localparam int ROUTES_PER_PHASE = 32;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last_flag;
    } route_point_t;

    // Scoreboard: walks the route itself from each accepted request and holds the
    // points still due, oldest first.
    class route_scoreboard;
        int ratio_scale;
        int cone_threshold;
        int cursor_x, cursor_y, cursor_z;
        int steps_left;
        route_point_t route_points_due[$];
        int points_checked;
        int failures;

        function new();
            ratio_scale    = vrs_pkg::RATIO_RESET;
            cone_threshold = vrs_pkg::THRESH_RESET;
            cursor_x = 0;
            cursor_y = 0;
            cursor_z = 0;
            steps_left = 0;
            points_checked = 0;
            failures = 0;
        endfunction

        function void set_cone(int ratio, int threshold);
            ratio_scale    = ratio;
            cone_threshold = threshold;
        endfunction

        function int pending();
            return route_points_due.size();
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int direction_of(int v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        // Step a smaller axis only when it lies inside the cone around the major axis
        function int minor_step(int comp, int largest);
            if (comp == 0)
                return 0;
            if ((largest * ratio_scale) / magnitude(comp) <= cone_threshold)
                return direction_of(comp);
            return 0;
        endfunction

        // Work out the whole route of one request and queue its points
        function void note_request(coord_t sx, coord_t sy, coord_t sz,
                                   coord_t dx, coord_t dy, coord_t dz);
            int vx, vy, vz;
            int ax, ay, az;
            int stx, sty, stz;
            route_point_t pt;
            cursor_x = dx;
            cursor_y = dy;
            cursor_z = dz;
            steps_left = magnitude(cursor_x - sx);
            if (magnitude(cursor_y - sy) > steps_left)
                steps_left = magnitude(cursor_y - sy);
            if (magnitude(cursor_z - sz) > steps_left)
                steps_left = magnitude(cursor_z - sz);
            while (steps_left > 0) begin
                pt.x = coord_t'(cursor_x);
                pt.y = coord_t'(cursor_y);
                pt.z = coord_t'(cursor_z);
                pt.last_flag = (steps_left == 1);
                route_points_due.insert(route_points_due.size(), pt);
                vx = cursor_x - sx;
                vy = cursor_y - sy;
                vz = cursor_z - sz;
                ax = magnitude(vx);
                ay = magnitude(vy);
                az = magnitude(vz);
                // ties go to x, then y
                if (ax >= ay && ax >= az) begin
                    stx = direction_of(vx);
                    sty = minor_step(vy, ax);
                    stz = minor_step(vz, ax);
                end else if (ay >= az) begin
                    sty = direction_of(vy);
                    stx = minor_step(vx, ay);
                    stz = minor_step(vz, ay);
                end else begin
                    stz = direction_of(vz);
                    stx = minor_step(vx, az);
                    sty = minor_step(vy, az);
                end
                cursor_x -= stx;
                cursor_y -= sty;
                cursor_z -= stz;
                steps_left--;
            end
        endfunction

        function void check_point(logic [PNT_W-1:0] word, logic last_flag);
            route_point_t want;
            route_point_t got;
            logic [PNT_W-3*COORD_BITS-1:0] pad;
            got.x = word[COORD_BITS-1:0];
            got.y = word[2*COORD_BITS-1:COORD_BITS];
            got.z = word[3*COORD_BITS-1:2*COORD_BITS];
            got.last_flag = last_flag;
            pad = word[PNT_W-1:3*COORD_BITS];
            points_checked++;
            if (route_points_due.size() == 0) begin
                note_failure($sformatf("route point %0d (%0d,%0d,%0d) last=%0b not expected",
                                       points_checked, got.x, got.y, got.z, got.last_flag));
                return;
            end
            want = route_points_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.last_flag !== want.last_flag || pad !== '0)
                note_failure($sformatf(
                    {"route point %0d: expected (%0d,%0d,%0d) last=%0b, ",
                     "got (%0d,%0d,%0d) last=%0b pad=%h"},
                    points_checked, want.x, want.y, want.z, want.last_flag,
                    got.x, got.y, got.z, got.last_flag, pad));
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [REQ_W-1:0]              s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [PNT_W-1:0]              m_tdata;
    logic                          m_tlast;
    logic                          cfg_we = 1'b0;
    logic [vrs_pkg::CFG_IDX_W-1:0] cfg_index = vrs_pkg::CFG_RATIO_SCALE;
    logic [vrs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    route_scoreboard sb = new();

    bit steady_pace;   // both sides run without idling while set
    bit rx_hold_req;   // ask the receiver for one long hold-off
    int hold_left;
    int stall_cycles;

    // src x,y,z then dst x,y,z
    int directed_routes [20][6] = '{
        '{-32, -32, -32,  31,  31,  31},   // longest diagonal
        '{ 31,  31,  31, -32, -32, -32},
        '{  0,   0,   0,   0,   0,   0},   // equal points
        '{-32,  31, -32, -32,  31, -32},   // equal points at the extremes
        '{  0,   0,   0,  31,   0,   0},
        '{  0,   0,   0,   0, -32,   0},
        '{  0,   0,   0,   0,   0,  31},
        '{-32,   0,   0,  31, -32,  31},
        '{  0,   0,   0,   5,   5,   0},   // x/y tie
        '{  0,   0,   0,   0,  -6,   6},   // y/z tie
        '{  1,   1,   1,  -3,   4,  -3},   // x/z tie
        '{  0,   0,   0,   7,   7,   7},   // three-way tie
        '{  0,   0,   0,  20,   3,   1},
        '{  0,   0,   0,  20,  10,  19},
        '{ 10, -10,   5,  11, -10,   5},   // single point
        '{ 31, -32,   0, -32,  31,   0},
        '{  0,   0,   0,  -1,  -1,  -1},
        '{  5,   5,   5,   5,   5,   5},
        '{-32, -32, -32,  31,  30,  -1},
        '{  0,   0,   0, -30,  17,  -9}
    };

    int phase_ratio  [NUM_PHASES] = '{10,   0, 255,  255,    1, 10, 0, 0};
    int phase_thresh [NUM_PHASES] = '{20,   0,   0, 4095, 4095, 20, 0, 0};

    vector_route_stepper_26dir #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Offer one request, idling at random first; return once the transaction is taken
    task automatic send_route(input int pt[6]);
        while (!steady_pace && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(REQ_W-6*COORD_BITS){1'b0}},
                     coord_t'(pt[5]), coord_t'(pt[4]), coord_t'(pt[3]),
                     coord_t'(pt[2]), coord_t'(pt[1]), coord_t'(pt[0])};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(coord_t'(pt[0]), coord_t'(pt[1]), coord_t'(pt[2]),
                        coord_t'(pt[3]), coord_t'(pt[4]), coord_t'(pt[5]));
    endtask

    // Mix of long random routes, short ones and equal points
    task automatic send_random_route();
        int pt[6];
        int mode;
        int lo, hi;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            pt[a] = $urandom_range(0, 63) - 32;
            if (mode == 0) begin
                pt[a+3] = pt[a];
            end else if (mode <= 3) begin
                lo = (pt[a] - 3 < -32) ? -32 : pt[a] - 3;
                hi = (pt[a] + 3 > 31) ? 31 : pt[a] + 3;
                pt[a+3] = lo + int'($urandom_range(0, hi - lo));
            end else begin
                pt[a+3] = $urandom_range(0, 63) - 32;
            end
        end
        send_route(pt);
    endtask

    // Write both cone settings; only called while the block is idle
    task automatic write_cone(input int ratio, input int threshold);
        cfg_we    <= 1'b1;
        cfg_index <= vrs_pkg::CFG_RATIO_SCALE;
        cfg_wdata <= vrs_pkg::CFG_DATA_W'(ratio);
        @(posedge aclk);
        cfg_index <= vrs_pkg::CFG_CONE_THRESHOLD;
        cfg_wdata <= vrs_pkg::CFG_DATA_W'(threshold);
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_cone(ratio, threshold);
    endtask

    // Drop valid, wait for every due point, then let a trailing empty request finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, a steady stretch and one long hold-off
    initial begin
        hold_left = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady_pace) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Check every route point on its transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_point(m_tdata, m_tlast);
    end

    // Watchdog: end the run if neither side moves for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Main sequence: reset, then phases of cone settings, each with its routes
    initial begin
        steady_pace = 1'b0;
        rx_hold_req = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        phase_ratio[6]  = $urandom_range(0, 255);
        phase_thresh[6] = $urandom_range(0, 4095);
        phase_ratio[7]  = $urandom_range(0, 255);
        phase_thresh[7] = $urandom_range(0, 4095);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // phase 0 runs on the reset values
            if (ph > 0) begin
                settle();
                write_cone(phase_ratio[ph], phase_thresh[ph]);
            end
            steady_pace = (ph == 4);
            if (ph == 0) begin
                foreach (directed_routes[i])
                    send_route(directed_routes[i]);
            end else begin
                // ties again under the new cone, so some stay unstepped
                for (int i = 8; i < 12; i++)
                    send_route(directed_routes[i]);
            end
            // hold the receiver off while requests keep coming
            if (ph == 2)
                rx_hold_req = 1'b1;
            repeat (ROUTES_PER_PHASE) send_random_route();
        end

        settle();
        if (sb.pending() != 0)
            sb.note_failure($sformatf("%0d route points never arrived", sb.pending()));
        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
